FILE: rtl/core/adq_pkg.sv
// ----------------------------------------------------------------------------
// adq_pkg: shared types and constants for the affine dequantizer
// Holds field widths, register indexes and the element record between stages.
// ----------------------------------------------------------------------------
`default_nettype none
package adq_pkg;
	localparam int MaxChannels = 4096;
	localparam int ChW = $clog2(MaxChannels);
	localparam int StrideLimit = 16777216;
	localparam logic [31:0] CanonNan = 32'h7FC00000;

	typedef enum logic [1:0] {
		REG_FORMAT = 2'd0,
		REG_COUNT  = 2'd1,
		REG_STRIDE = 2'd2,
		REG_TOTAL  = 2'd3
	} reg_idx_t;

	localparam logic OP_TABLE = 1'b0;
	localparam logic OP_DATA  = 1'b1;

	// one element handed from front to back
	typedef struct packed {
		logic signed [7:0]  q;
		logic [ChW-1:0]     ch;
		logic               last;
	} elem_t;
endpackage
`default_nettype wire

FILE: rtl/core/adq_ram.sv
// ----------------------------------------------------------------------------
// adq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module adq_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]              rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/core/adq_front.sv
// ----------------------------------------------------------------------------
// adq_front: element splitter and channel counter
// Splits data bytes into elements, one per cycle when not stalled, and tracks position counters.
// ----------------------------------------------------------------------------
`default_nettype none
module adq_front import adq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fmt,
	input  wire logic [12:0] count,
	input  wire logic [24:0] stride,
	input  wire logic [31:0] total,
	input  wire logic        byte_valid,
	output logic             byte_ready,
	input  wire logic [7:0]  byte_data,
	output logic             el_valid,
	input  wire logic        el_ready,
	output elem_t            el
);
	logic        hi_pend_q;
	logic [3:0]  hi_nib_q;
	logic [23:0] spos_q;
	logic [ChW-1:0] cpos_q;
	logic [31:0] epos_q;
	logic [13:0] eff_count;
	logic [24:0] eff_stride;
	logic [31:0] eff_total;
	logic [ChW-1:0] ch;
	logic [ChW:0]   ch_next;
	logic [24:0] s_next;
	logic        last, fire;
	logic signed [7:0] q;

	always_comb begin
		eff_count = (count == 13'd0) ? 14'd1 :
			({1'b0, count} > 14'(MaxChannels)) ? 14'(MaxChannels) : {1'b0, count};
		eff_stride = (stride == 25'd0) ? 25'd1 :
			(stride > 25'(StrideLimit)) ? 25'(StrideLimit) : stride;
		eff_total = (total == 32'd0) ? 32'd1 : total;
		ch = ({2'b0, cpos_q} >= eff_count) ? '0 : cpos_q;
		last = epos_q == eff_total - 32'd1;
		if (hi_pend_q) q = {{4{hi_nib_q[3]}}, hi_nib_q};
		else if (fmt) q = {{4{byte_data[3]}}, byte_data[3:0]};
		else q = byte_data;
		s_next = {1'b0, spos_q} + 25'd1;
		ch_next = {1'b0, ch} + 1'b1;
	end

	assign el_valid = hi_pend_q || byte_valid;
	assign byte_ready = !hi_pend_q && el_ready;
	assign fire = el_valid && el_ready;
	always_comb begin
		el = '0;
		el.q = q;
		el.ch = ch;
		el.last = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_pend_q <= 1'b0;
			hi_nib_q <= '0;
			spos_q <= '0;
			cpos_q <= '0;
			epos_q <= '0;
		end else if (fire) begin
			if (hi_pend_q) hi_pend_q <= 1'b0;
			else if (fmt && !last) begin
				hi_pend_q <= 1'b1;
				hi_nib_q <= byte_data[7:4];
			end
			if (last) begin
				spos_q <= '0;
				cpos_q <= '0;
				epos_q <= '0;
			end else begin
				epos_q <= epos_q + 32'd1;
				if (s_next >= eff_stride) begin
					spos_q <= '0;
					cpos_q <= ({1'b0, ch_next} >= eff_count) ? '0 : ch_next[ChW-1:0];
				end else begin
					spos_q <= s_next[23:0];
					cpos_q <= ch;
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/adq_fifo.sv
// ----------------------------------------------------------------------------
// adq_fifo: two-entry element queue
// Decouples the element splitter from the multiply pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module adq_fifo import adq_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  elem_t     in_el,
	output logic      out_valid,
	input  wire logic out_ready,
	output elem_t     out_el
);
	elem_t      ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_el = ent_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= in_el;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue overflow");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !out_ready) |=> cnt_q == 2'd2)
		else $error("full queue lost an entry");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 && !in_valid) |=> cnt_q == 2'd0)
		else $error("entry appeared from nowhere");
endmodule
`default_nettype wire

FILE: rtl/core/adq_back.sv
// ----------------------------------------------------------------------------
// adq_back: table lookup and fp32 multiply pipeline
// s1 reads tables, s2 converts difference to float, s3 multiplies mantissas,
// s4 rounds and packs. Output stalls freeze the whole pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module adq_back import adq_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           tw_en,
	input  wire logic [ChW-1:0] tw_idx,
	input  wire logic [31:0]    tw_scale,
	input  wire logic [15:0]    tw_zero,
	input  wire logic           el_valid,
	output logic                el_ready,
	input  elem_t               el,
	output logic                res_valid,
	input  wire logic           res_ready,
	output logic [31:0]         value_bits,
	output logic [ChW-1:0]      channel,
	output logic                final_res
);
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [7:0] q_s1;
	logic [ChW-1:0] ch_s1, ch_s2, ch_s3, ch_s4;
	logic last_s1, last_s2, last_s3, last_s4;
	logic [31:0] scale_rd;
	logic [15:0] zero_rd;

	assign adv = !v_s4 || res_ready;
	assign el_ready = adv;

	adq_ram #(.Width(32), .Depth(MaxChannels)) u_scale (
		.clk(clk), .we(tw_en), .waddr(tw_idx), .wdata(tw_scale),
		.re(adv && el_valid), .raddr(el.ch), .rdata(scale_rd));
	adq_ram #(.Width(16), .Depth(MaxChannels)) u_zero (
		.clk(clk), .we(tw_en), .waddr(tw_idx), .wdata(tw_zero),
		.re(adv && el_valid), .raddr(el.ch), .rdata(zero_rd));

	// s2: difference to magnitude with leading one at bit 16
	logic signed [16:0] diff;
	logic [16:0] mag;
	logic [4:0]  lz;
	logic [16:0] norm;
	always_comb begin
		diff = 17'(q_s1) - 17'($signed(zero_rd));
		mag = diff[16] ? 17'(-diff) : 17'(diff);
		lz = 5'd17;
		for (int i = 0; i < 17; i++) if (mag[i]) lz = 5'(16 - i);
		norm = mag << lz;
	end
	logic        dsign_s2, dzero_s2;
	logic [4:0]  dexp_s2;
	logic [16:0] dman_s2;
	logic [31:0] sc_s2;

	// s3: special cases and 24x17 mantissa product
	logic        ssign, szero, sinf, snan;
	logic [7:0]  sexp;
	logic [23:0] sman;
	logic signed [10:0] se;
	always_comb begin
		ssign = sc_s2[31];
		sexp = sc_s2[30:23];
		snan = sexp == 8'hFF && sc_s2[22:0] != '0;
		sinf = sexp == 8'hFF && sc_s2[22:0] == '0;
		szero = sexp == 8'd0 && sc_s2[22:0] == '0;
		sman = {sexp != 8'd0, sc_s2[22:0]};
		se = (sexp == 8'd0) ? 11'sd1 : 11'(sexp);
	end
	logic        sign_s3, spec_s3;
	logic [31:0] spec_val_s3;
	logic [40:0] prod_s3;
	logic signed [11:0] e_s3;

	// s4: normalize with subnormal support, round nearest even
	logic [5:0]  plz;
	logic [40:0] pn;
	logic signed [11:0] ex;
	logic [6:0]  rsh;
	logic [64:0] wide, shd;
	logic [23:0] mk;
	logic        gb, st;
	logic [24:0] mr;
	logic [31:0] res;
	always_comb begin
		plz = 6'd0;
		for (int i = 0; i < 41; i++) if (prod_s3[i]) plz = 6'(40 - i);
		pn = prod_s3 << plz;
		ex = e_s3 - 12'(plz);
		rsh = 7'd0;
		if (ex < 12'sd1) rsh = (ex < -12'sd30) ? 7'd32 : 7'(12'sd1 - ex);
		wide = {pn, 24'd0};
		shd = wide >> rsh;
		mk = shd[64:41];
		gb = shd[40];
		st = shd[39:0] != '0;
		mr = {1'b0, mk} + 25'(gb && (st || mk[0]));
		if (spec_s3) res = spec_val_s3;
		else if (ex < 12'sd1) begin
			res = {sign_s3, 8'(mr[23]), mr[22:0]};
		end else if (mr[24]) begin
			res = (ex + 12'sd1 >= 12'sd255) ? {sign_s3, 8'hFF, 23'd0}
				: {sign_s3, 8'(ex + 12'sd1), 23'd0};
		end else begin
			res = (ex >= 12'sd255) ? {sign_s3, 8'hFF, 23'd0}
				: {sign_s3, 8'(ex), mr[22:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s1 <= el.q;
			ch_s1 <= el.ch;
			last_s1 <= el.last;
			dsign_s2 <= diff[16];
			dzero_s2 <= mag == '0;
			dexp_s2 <= 5'd16 - lz;
			dman_s2 <= norm;
			sc_s2 <= scale_rd;
			ch_s2 <= ch_s1;
			last_s2 <= last_s1;
			sign_s3 <= dsign_s2 ^ ssign;
			spec_s3 <= snan || sinf || szero || dzero_s2;
			if (snan || (sinf && dzero_s2)) spec_val_s3 <= CanonNan;
			else if (sinf) spec_val_s3 <= {dsign_s2 ^ ssign, 8'hFF, 23'd0};
			else spec_val_s3 <= {dsign_s2 ^ ssign, 31'd0};
			prod_s3 <= sman * dman_s2;
			// product bit 40 weighs 2^(se-127+dexp+1)
			e_s3 <= 12'(se) + 12'(dexp_s2) + 12'sd1;
			ch_s3 <= ch_s2;
			last_s3 <= last_s2;
			value_bits <= res;
			ch_s4 <= ch_s3;
			last_s4 <= last_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= el_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign res_valid = v_s4;
	assign channel = ch_s4;
	assign final_res = last_s4;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !res_ready) |=> (v_s4 && $stable(value_bits) && $stable(ch_s4)))
		else $error("stalled result changed");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s3) |=> v_s4)
		else $error("result dropped in pipeline");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s1) && $stable(v_s2) && $stable(v_s3))
		else $error("pipeline moved while stalled");
endmodule
`default_nettype wire

FILE: rtl/core/affine_dequantize_int8_int4_to_fp32_top.sv
// a data byte's first element passes the queue and back stages s1, s2, s3 and s4 before its result is valid
// throughput: one result per cycle while m_tready is high; int8 bytes at 1 per cycle, int4 bytes
//   only once the element splitter, which emits one nibble per cycle, has sent the high nibble
// a table write waits until no element sits in the splitter or queue
// reset clears counters and pipeline valids and sets config registers to defaults; tables are undefined until written
// ----------------------------------------------------------------------------
// affine_dequantize_int8_int4_to_fp32_top: int8/int4 to fp32 dequantizer
// Front splits bytes into elements, a queue decouples, back multiplies.
// ----------------------------------------------------------------------------
`default_nettype none
module affine_dequantize_int8_int4_to_fp32_top import adq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// table_index, scale_bits, zero_offset, packed_byte
	input  wire logic [71:0] s_tdata,
	// opcode
	input  wire logic        s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// value_bits, channel
	output logic [47:0]      m_tdata,
	// final_res
	output logic             m_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	logic        fmt_q;
	logic [12:0] count_q;
	logic [24:0] stride_q;
	logic [31:0] total_q;
	logic        is_data, tw_en, data_valid, data_ready;
	logic        fe_valid, fe_ready, be_valid, be_ready;
	elem_t       fe_el, be_el;
	logic [31:0] vbits;
	logic [ChW-1:0] ch_out;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= 1'b0;
			count_q <= 13'd1;
			stride_q <= 25'd1;
			total_q <= 32'd1;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FORMAT: fmt_q <= cfg_data[0];
				REG_COUNT:  count_q <= cfg_data[12:0];
				REG_STRIDE: stride_q <= cfg_data[24:0];
				REG_TOTAL:  total_q <= cfg_data;
			endcase
		end
	end

	assign is_data = s_tuser == OP_DATA;
	// a table write must not overtake elements that still have to read the tables
	assign s_tready = is_data ? data_ready : !(fe_valid || be_valid);
	assign tw_en = s_tvalid && s_tready && !is_data;
	assign data_valid = s_tvalid && is_data;

	adq_front u_front (
		.clk(clk), .arst_n(arst_n), .fmt(fmt_q), .count(count_q),
		.stride(stride_q), .total(total_q), .byte_valid(data_valid),
		.byte_ready(data_ready), .byte_data(s_tdata[67:60]),
		.el_valid(fe_valid), .el_ready(fe_ready), .el(fe_el));

	adq_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .in_valid(fe_valid), .in_ready(fe_ready),
		.in_el(fe_el), .out_valid(be_valid), .out_ready(be_ready), .out_el(be_el));

	adq_back u_back (
		.clk(clk), .arst_n(arst_n), .tw_en(tw_en), .tw_idx(s_tdata[11:0]),
		.tw_scale(s_tdata[43:12]), .tw_zero(s_tdata[59:44]),
		.el_valid(be_valid), .el_ready(be_ready), .el(be_el),
		.res_valid(m_tvalid), .res_ready(m_tready), .value_bits(vbits),
		.channel(ch_out), .final_res(m_tlast));

	assign m_tdata = {4'd0, ch_out, vbits};
endmodule
`default_nettype wire
